[rtl/rotation_matrix_to_roll_pitch_yaw_assert.svh]
// Assertion macros for the rotation matrix to roll, pitch and yaw block.
// Expects signals clk and rst in the scope where the macros are used.
`ifndef ROTATION_MATRIX_TO_ROLL_PITCH_YAW_ASSERT_SVH
`define ROTATION_MATRIX_TO_ROLL_PITCH_YAW_ASSERT_SVH

// same-cycle implication
`define RMRPY_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RMRPY_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rmrpy_pkg.sv]
// Shared types, constants and small functions for the roll, pitch and yaw block.
// No dependencies.
package rmrpy_pkg;

  localparam int MAT_W          = 16;
  localparam int MARGIN_W       = 11;
  localparam int ANGLE_W        = 16;
  localparam int PITCH_W        = 15;
  localparam int S20_W          = 22;
  localparam int RAD_W          = 42;
  localparam int ROOT_W         = 21;
  localparam int REM_W          = 23;
  localparam int SQRT_STEPS     = 21;
  localparam int CW             = 24;
  localparam int ZW             = 24;
  localparam int MAX_STEPS      = 24;
  localparam int ONE_Q14        = 16384;
  localparam int PITCH_LIMIT    = 12868;
  localparam int YAW_LOCK_Q13   = 6434;

  localparam logic signed [ZW-1:0] HALF_PI_Q20    = 24'sd1647099;
  localparam logic signed [ZW-1:0] QUARTER_PI_Q20 = 24'sd823550;

  typedef enum logic [1:0] {
    LOCK_NONE = 2'd0,
    LOCK_POS  = 2'd1,
    LOCK_NEG  = 2'd2
  } lock_t;

  typedef struct packed {
    lock_t                     lock;
    logic signed [MAT_W-1:0]   ry;
    logic signed [MAT_W-1:0]   rx;
    logic signed [MAT_W-1:0]   yy;
    logic signed [MAT_W-1:0]   yx;
    logic signed [S20_W-1:0]   s20;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 24'sd823550;
      1:  r = 24'sd486170;
      2:  r = 24'sd256879;
      3:  r = 24'sd130396;
      4:  r = 24'sd65451;
      5:  r = 24'sd32757;
      6:  r = 24'sd16383;
      7:  r = 24'sd8192;
      8:  r = 24'sd4096;
      9:  r = 24'sd2048;
      10: r = 24'sd1024;
      11: r = 24'sd512;
      12: r = 24'sd256;
      13: r = 24'sd128;
      14: r = 24'sd64;
      15: r = 24'sd32;
      16: r = 24'sd16;
      17: r = 24'sd8;
      18: r = 24'sd4;
      19: r = 24'sd2;
      20: r = 24'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round Q.20 to Q3.13: add half an LSB, then floor
  function automatic logic signed [ZW-1:0] to_q13(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    t = z + 24'sd64;
    return t >>> 7;
  endfunction

endpackage

[rtl/rmrpy_if.sv]
// Valid/ready channel interfaces: matrix beats in, angle beats out.
// Depends on rmrpy_pkg.
interface rmrpy_mat_if import rmrpy_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [MAT_W-1:0] m11;
  logic signed [MAT_W-1:0] m12;
  logic signed [MAT_W-1:0] m13;
  logic signed [MAT_W-1:0] m21;
  logic signed [MAT_W-1:0] m31;
  logic signed [MAT_W-1:0] m32;
  logic signed [MAT_W-1:0] m33;

  modport source (output valid, m11, m12, m13, m21, m31, m32, m33, input ready);
  modport sink   (input valid, m11, m12, m13, m21, m31, m32, m33, output ready);
endinterface

interface rmrpy_ang_if import rmrpy_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] roll_angle;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic signed [ANGLE_W-1:0] yaw_angle;
  logic [1:0]                lock_case;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, lock_case, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, lock_case, output ready);
endinterface

[rtl/rmrpy_cordic.sv]
// Pipelined vectoring CORDIC: atan2(y, x) in Q.20 radians, one stage per micro-rotation.
// Depends on rmrpy_pkg. All stages advance only at enable.
module rmrpy_cordic import rmrpy_pkg::*; #(
  parameter int STEPS = 14
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] x_in,
  output logic signed [ZW-1:0] z_out
);

  logic signed [CW-1:0] xs [0:STEPS];
  logic signed [CW-1:0] ys [0:STEPS];
  logic signed [ZW-1:0] zs [0:STEPS];
  logic                 zero [0:STEPS];

  // move into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          xs[0] <= y_in;
          ys[0] <= -x_in;
          zs[0] <= HALF_PI_Q20;
        end else begin
          xs[0] <= -y_in;
          ys[0] <= x_in;
          zs[0] <= -HALF_PI_Q20;
        end
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_step(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_step(i);
        end
      end
    end
  end

  assign z_out = zero[STEPS] ? '0 : zs[STEPS];

endmodule

[rtl/rotation_matrix_to_roll_pitch_yaw.sv]
// Top level: rotation matrix to roll, pitch and yaw (Z-Y-X), fully pipelined.
// Depends on rmrpy_pkg, rmrpy_if.sv, rmrpy_cordic and the assertion macro header.
//
//   channel   dir  contents
//   mat       in   m11 m12 m13 m21 m31 m32 m33, Q1.14
//   ang       out  roll_angle yaw_angle (Q3.13), pitch_angle (Q2.13), lock_case
//   cfg_wr_*  in   gimbal_margin, 11 bit
//
// One beat enters per cycle while no result is held at the output. Steps is
// ANGLE_ITERATIONS held to at most 24. Stages: two front stages, 21 square root
// stages, CORDIC, output register.
// Reset clears the valid bits and the margin register.
// A result held at the output stalls every stage at once; nothing moves or drops.
`include "rotation_matrix_to_roll_pitch_yaw_assert.svh"
module rotation_matrix_to_roll_pitch_yaw import rmrpy_pkg::*; #(
  parameter int ANGLE_ITERATIONS = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [MARGIN_W-1:0] cfg_wr_data,
  rmrpy_mat_if.sink           mat,
  rmrpy_ang_if.source         ang
);

  localparam int Steps = (ANGLE_ITERATIONS < MAX_STEPS) ? ANGLE_ITERATIONS : MAX_STEPS;
  localparam int CLat  = Steps + 1;

  logic [MARGIN_W-1:0] gimbal_margin;
  logic                en;

  assign en = !ang.valid || ang.ready;
  assign mat.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gimbal_margin <= '0;
    end else if (cfg_wr_en) begin
      gimbal_margin <= cfg_wr_data;
    end
  end

  // stage A: saturate m31, lock test, pick operands
  logic        a_vld;
  side_t       a_side;
  side_t       a_next;
  logic signed [17:0] m31s;
  logic signed [17:0] d_hi;
  logic signed [17:0] d_lo;
  logic signed [17:0] mg;

  always_comb begin
    m31s = 18'(mat.m31);
    if (m31s > 18'(ONE_Q14)) begin
      m31s = 18'(ONE_Q14);
    end
    if (m31s < -18'(ONE_Q14)) begin
      m31s = -18'(ONE_Q14);
    end
    mg   = signed'({7'b0, gimbal_margin});
    d_hi = 18'(ONE_Q14) - m31s;
    d_lo = m31s + 18'(ONE_Q14);
    a_next.yy  = mat.m21;
    a_next.yx  = mat.m11;
    a_next.s20 = S20_W'(-m31s) <<< 6;
    if (d_hi <= mg) begin
      a_next.lock = LOCK_POS;
    end else if (d_lo <= mg) begin
      a_next.lock = LOCK_NEG;
    end else begin
      a_next.lock = LOCK_NONE;
    end
    if (a_next.lock == LOCK_NONE) begin
      a_next.ry = mat.m32;
      a_next.rx = mat.m33;
    end else begin
      a_next.ry = mat.m12;
      a_next.rx = mat.m13;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= mat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side <= a_next;
    end
  end

  // stage B and square root: floor(sqrt(2^40 - s20^2)), one result bit per stage
  logic              sq_vld  [0:SQRT_STEPS];
  side_t             sq_side [0:SQRT_STEPS];
  logic [RAD_W-1:0]  sq_v    [0:SQRT_STEPS];
  logic [REM_W-1:0]  sq_rem  [0:SQRT_STEPS];
  logic [ROOT_W-1:0] sq_root [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= a_side;
      sq_v[0]    <= (RAD_W'(1) << 40) - RAD_W'(a_side.s20 * a_side.s20);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [REM_W+1:0] rn;
    logic [REM_W-1:0] trial;
    assign rn    = {sq_rem[k], sq_v[k][RAD_W-1:RAD_W-2]};
    assign trial = {sq_root[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_side[k+1] <= sq_side[k];
        sq_v[k+1]    <= sq_v[k] << 2;
        if (rn >= {2'b00, trial}) begin
          sq_rem[k+1]  <= REM_W'(rn - {2'b00, trial});
          sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= REM_W'(rn);
          sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // three angle pipelines in parallel
  side_t                sq_out;
  logic signed [ZW-1:0] z_pitch;
  logic signed [ZW-1:0] z_roll;
  logic signed [ZW-1:0] z_yaw;

  assign sq_out = sq_side[SQRT_STEPS];

  rmrpy_cordic #(.STEPS(Steps)) u_pitch (
    .clk   (clk),
    .en    (en),
    .y_in  (CW'(sq_out.s20)),
    .x_in  (CW'({1'b0, sq_root[SQRT_STEPS]})),
    .z_out (z_pitch)
  );

  rmrpy_cordic #(.STEPS(Steps)) u_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (CW'(sq_out.ry)),
    .x_in  (CW'(sq_out.rx)),
    .z_out (z_roll)
  );

  rmrpy_cordic #(.STEPS(Steps)) u_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (CW'(sq_out.yy)),
    .x_in  (CW'(sq_out.yx)),
    .z_out (z_yaw)
  );

  logic  c_vld  [0:CLat-1];
  lock_t c_lock [0:CLat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld[0] <= 1'b0;
    end else if (en) begin
      c_vld[0] <= sq_vld[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_lock[0] <= sq_out.lock;
    end
  end

  for (genvar j = 0; j < CLat - 1; j++) begin : g_lock
    always_ff @(posedge clk) begin
      if (rst) begin
        c_vld[j+1] <= 1'b0;
      end else if (en) begin
        c_vld[j+1] <= c_vld[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c_lock[j+1] <= c_lock[j];
      end
    end
  end

  // output register: rounding, lock constants, pitch clamp
  logic signed [ZW-1:0] rz;
  logic signed [ZW-1:0] pq;
  logic signed [ZW-1:0] yq;
  logic signed [ZW-1:0] rq;

  always_comb begin
    rz = z_roll;
    pq = to_q13(z_pitch);
    yq = to_q13(z_yaw);
    case (c_lock[CLat-1])
      LOCK_POS: begin
        rz = z_roll - QUARTER_PI_Q20;
        pq = to_q13(-HALF_PI_Q20);
        yq = to_q13(QUARTER_PI_Q20);
      end
      LOCK_NEG: begin
        rz = z_roll + QUARTER_PI_Q20;
        pq = to_q13(HALF_PI_Q20);
        yq = to_q13(QUARTER_PI_Q20);
      end
      default: begin
      end
    endcase
    rq = to_q13(rz);
    if (pq > ZW'(PITCH_LIMIT)) begin
      pq = ZW'(PITCH_LIMIT);
    end
    if (pq < -ZW'(PITCH_LIMIT)) begin
      pq = -ZW'(PITCH_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ang.valid <= 1'b0;
    end else if (en) begin
      ang.valid <= c_vld[CLat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang.roll_angle  <= rq[ANGLE_W-1:0];
      ang.pitch_angle <= pq[PITCH_W-1:0];
      ang.yaw_angle   <= yq[ANGLE_W-1:0];
      ang.lock_case   <= c_lock[CLat-1];
    end
  end

  `RMRPY_ASSERT_NEXT(a_accept_fills, mat.valid && mat.ready, a_vld, "accepted beat lost at stage A")
  `RMRPY_ASSERT_NOW(a_root_range, sq_vld[SQRT_STEPS], sq_root[SQRT_STEPS] <= (ROOT_W'(1) << 20), "square root out of range")
  `RMRPY_ASSERT_NOW(a_pitch_range, ang.valid, (ang.pitch_angle <= PITCH_W'(PITCH_LIMIT)) && (ang.pitch_angle >= -PITCH_W'(PITCH_LIMIT)), "pitch beyond limit")
  `RMRPY_ASSERT_NOW(a_lock_pos, ang.valid && (ang.lock_case == LOCK_POS), (ang.pitch_angle == -PITCH_W'(PITCH_LIMIT)) && (ang.yaw_angle == ANGLE_W'(YAW_LOCK_Q13)), "lock near +1 gives wrong fixed angles")

endmodule

[tb/sv/tb_rmrpy_if_probe.sv]
// Bench-side helpers for the roll, pitch and yaw block: typed beat records.
// Depends on rmrpy_pkg; the channel interfaces come from rtl/rmrpy_if.sv.
`timescale 1ns / 1ps
package tb_rmrpy_pkg;
  import rmrpy_pkg::*;

  typedef struct {
    logic signed [MAT_W-1:0] m11, m12, m13, m21, m31, m32, m33;
  } matrix_beat_t;

  typedef struct {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] yaw;
    lock_t                     lock;
  } angle_beat_t;
endpackage

[tb/sv/tb_top.sv]
// Testbench for rotation_matrix_to_roll_pitch_yaw: drives matrix beats with bursty
// gaps, stalls the angle channel, and checks each beat against a bit-true predictor.
// Depends on rmrpy_pkg, tb_rmrpy_pkg, rmrpy_if.sv and the block itself.
`timescale 1ns / 1ps
module tb_top;
  import rmrpy_pkg::*;
  import tb_rmrpy_pkg::*;

  localparam int ITERS = 14;
  localparam int LATENCY = ITERS + 25;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint HALF_PI = 1647099;
  localparam longint QUARTER_PI = 823550;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [MARGIN_W-1:0] cfg_wr_data = '0;
  logic [MARGIN_W-1:0] margin_model = '0;

  rmrpy_mat_if mat_ch ();
  rmrpy_ang_if ang_ch ();

  angle_beat_t expected_angles[$];
  int mismatches = 0;
  longint cycles = 0;

  rotation_matrix_to_roll_pitch_yaw #(.ANGLE_ITERATIONS(ITERS)) DUT (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .mat(mat_ch.sink), .ang(ang_ch.source)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint isqrt(longint v);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic longint arc_step(int i);
    longint steps[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                          4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 21) ? steps[i] : 0;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI;
      end else begin
        x = -y; y = t; z = -HALF_PI;
      end
    end
    for (int i = 0; i < ITERS && i < MAX_STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += arc_step(i);
      end else begin
        x -= dx; y += dy; z -= arc_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint round_q13(longint z);
    return floor_shift(z + 64, 7);
  endfunction

  function automatic angle_beat_t predict_angles(matrix_beat_t m);
    angle_beat_t r;
    longint s31, s20, c20, pitch, roll, yaw, mg;
    mg = margin_model;
    s31 = m.m31;
    if (s31 > ONE_Q14) s31 = ONE_Q14;
    if (s31 < -ONE_Q14) s31 = -ONE_Q14;
    if (ONE_Q14 - s31 <= mg) begin
      r.lock = LOCK_POS;
      pitch = round_q13(-HALF_PI);
      yaw = round_q13(QUARTER_PI);
      roll = round_q13(vector_angle(m.m12, m.m13) - QUARTER_PI);
    end else if (s31 + ONE_Q14 <= mg) begin
      r.lock = LOCK_NEG;
      pitch = round_q13(HALF_PI);
      yaw = round_q13(QUARTER_PI);
      roll = round_q13(vector_angle(m.m12, m.m13) + QUARTER_PI);
    end else begin
      r.lock = LOCK_NONE;
      s20 = -s31 * 64;
      c20 = isqrt((64'sd1 <<< 40) - s20 * s20);
      pitch = round_q13(vector_angle(s20, c20));
      roll = round_q13(vector_angle(m.m32, m.m33));
      yaw = round_q13(vector_angle(m.m21, m.m11));
    end
    if (pitch > PITCH_LIMIT) pitch = PITCH_LIMIT;
    if (pitch < -PITCH_LIMIT) pitch = -PITCH_LIMIT;
    r.roll = roll[ANGLE_W-1:0];
    r.pitch = pitch[PITCH_W-1:0];
    r.yaw = yaw[ANGLE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      ang_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: ang_ch.ready <= 1'b1;
        1: ang_ch.ready <= ($urandom_range(0, 3) != 0);
        2: ang_ch.ready <= ($urandom_range(0, 1) == 0);
        default: ang_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    angle_beat_t want;
    if (!rst && ang_ch.valid && ang_ch.ready) begin
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected angle beat at cycle %0d", cycles);
      end else begin
        want = expected_angles.pop_front();
        if (ang_ch.roll_angle !== want.roll || ang_ch.pitch_angle !== want.pitch ||
            ang_ch.yaw_angle !== want.yaw || ang_ch.lock_case !== want.lock) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp r=%0d p=%0d y=%0d l=%0d got r=%0d p=%0d y=%0d l=%0d",
                     want.roll, want.pitch, want.yaw, want.lock, ang_ch.roll_angle,
                     ang_ch.pitch_angle, ang_ch.yaw_angle, ang_ch.lock_case);
        end
      end
    end
  end

  int burst_left = 0;

  task automatic send_matrix(matrix_beat_t m);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        mat_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    mat_ch.valid <= 1'b1;
    mat_ch.m11 <= m.m11; mat_ch.m12 <= m.m12; mat_ch.m13 <= m.m13;
    mat_ch.m21 <= m.m21; mat_ch.m31 <= m.m31; mat_ch.m32 <= m.m32;
    mat_ch.m33 <= m.m33;
    expected_angles.insert(expected_angles.size(), predict_angles(m));
    @(posedge clk);
    while (!mat_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    mat_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_margin(logic [MARGIN_W-1:0] v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    margin_model = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [MAT_W-1:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return MAT_W'($urandom);
      1: return MAT_W'($urandom_range(0, 32768)) - 16'sd16384;
      2: return ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384);
      3: return MAT_W'($urandom_range(0, 8)) - 16'sd4;
      default: return MAT_W'($urandom_range(0, 32768)) - 16'sd16384;
    endcase
  endfunction

  function automatic matrix_beat_t rand_matrix(int near_lock);
    matrix_beat_t m;
    m.m11 = rand_entry(); m.m12 = rand_entry(); m.m13 = rand_entry();
    m.m21 = rand_entry(); m.m32 = rand_entry(); m.m33 = rand_entry();
    m.m31 = rand_entry();
    if (near_lock) begin
      m.m31 = MAT_W'($urandom_range(0, 1100));
      m.m31 = $urandom_range(0, 1) ? 16'sd16384 - m.m31 : m.m31 - 16'sd16384;
    end
    return m;
  endfunction

  task automatic test_extremes();
    matrix_beat_t m;
    logic signed [MAT_W-1:0] vals[7] = '{16'sh7FFF, -16'sh8000, 16'sd16384, -16'sd16384,
                                         16'sd0, 16'sd1, -16'sd1};
    foreach (vals[i]) begin
      m = '{vals[i], vals[i], vals[i], vals[i], vals[i], vals[i], vals[i]};
      send_matrix(m);
    end
    m = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0};
    send_matrix(m);
    m = '{-16'sd100, 16'sd0, -16'sd5, 16'sd0, -16'sd16384, -16'sd7, -16'sd9};
    send_matrix(m);
    m = '{-16'sd100, 16'sd3, -16'sd5, -16'sd2, 16'sd100, 16'sd7, -16'sd9};
    send_matrix(m);
  endtask

  task automatic test_lock_cases();
    matrix_beat_t m;
    int m31s[8] = '{16384, 16383, 16384 - 1024, 16384 - 1025, -16384, -16383,
                    -16384 + 1024, 32767};
    foreach (m31s[i]) begin
      m = rand_matrix(0);
      m.m31 = MAT_W'(m31s[i]);
      send_matrix(m);
    end
  endtask

  task automatic test_random(int count, int lock_share);
    repeat (count) send_matrix(rand_matrix($urandom_range(0, 99) < lock_share));
  endtask

  initial begin
    mat_ch.valid = 1'b0;
    {mat_ch.m11, mat_ch.m12, mat_ch.m13, mat_ch.m21} = '0;
    {mat_ch.m31, mat_ch.m32, mat_ch.m33} = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_lock_cases();
    write_margin(11'd1024);
    test_extremes();
    test_lock_cases();
    test_random(250, 40);
    write_margin(11'd0);
    test_random(200, 30);
    write_margin(11'd2047);
    test_lock_cases();
    test_random(150, 50);
    write_margin(MARGIN_W'($urandom_range(1, 1023)));
    test_random(200, 40);
    drain_results();
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

[rotation_matrix_to_roll_pitch_yaw.f]
+incdir+rtl
rtl/rmrpy_pkg.sv
rtl/rmrpy_if.sv
rtl/rmrpy_cordic.sv
rtl/rotation_matrix_to_roll_pitch_yaw.sv
tb/sv/tb_rmrpy_if_probe.sv
tb/sv/tb_top.sv
